>>> sv/noncausal_fir_iq_dot_assert.svh
// Assertion helpers used by the filter datapath.
// They expect i_clk and i_rst_n in scope.
`ifndef NONCAUSAL_FIR_IQ_DOT_ASSERT_SVH
`define NONCAUSAL_FIR_IQ_DOT_ASSERT_SVH

// Condition holds at every clock edge outside reset
`define NFID_ASSERT_HOLD(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle
`define NFID_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> sv/nfid_pkg.sv
package nfid_pkg;

    // Field widths
    localparam int SMP_W  = 16;
    localparam int TAPI_W = 7;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 40;

    // Item function codes
    localparam logic FUNC_TAP    = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_RUN,
        S_DRAIN
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic tap_wr;
        logic push;
        logic pad;
        logic clear;
        logic dot_start;
        logic step;
        logic emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic emit_due;
        logic pad_left;
        logic frame_done;
        logic last_step;
        logic pipe_idle;
        logic out_free;
    } t_sts;

    // One input item
    typedef struct packed {
        logic                     func;
        logic [TAPI_W-1:0]        tap_index;
        logic signed [SMP_W-1:0]  tap_i;
        logic signed [SMP_W-1:0]  tap_q;
        logic signed [SMP_W-1:0]  sample_i;
        logic signed [SMP_W-1:0]  sample_q;
        logic                     frame_end;
    } t_item_in;

endpackage

>>> sv/nfid_if.sv
// Input item channel
interface nfid_in_if;
    import nfid_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     func;
    logic [TAPI_W-1:0]        tap_index;
    logic signed [SMP_W-1:0]  tap_i;
    logic signed [SMP_W-1:0]  tap_q;
    logic signed [SMP_W-1:0]  sample_i;
    logic signed [SMP_W-1:0]  sample_q;
    logic                     frame_end;

    modport source (
        output valid, func, tap_index, tap_i, tap_q, sample_i, sample_q, frame_end,
        input  ready
    );
    modport sink (
        input  valid, func, tap_index, tap_i, tap_q, sample_i, sample_q, frame_end,
        output ready
    );
endinterface

// Result item channel
interface nfid_out_if;
    import nfid_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ACC_W-1:0]  filtered;
    logic                     last_of_frame;

    modport source (
        output valid, filtered, last_of_frame,
        input  ready
    );
    modport sink (
        input  valid, filtered, last_of_frame,
        output ready
    );
endinterface

>>> sv/nfid_ctrl.sv
module nfid_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_func,
    input  nfid_pkg::t_sts  i_sts,
    output logic            o_in_ready,
    output nfid_pkg::t_cmd  o_cmd
);
    import nfid_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_func == FUNC_TAP) begin
                        o_cmd.tap_wr = 1'b1;
                    end else begin
                        o_cmd.push = 1'b1;
                        n_state    = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                // owed output first, then padding, then end-of-frame cleanup
                priority if (i_sts.emit_due) begin
                    o_cmd.dot_start = 1'b1;
                    n_state         = S_RUN;
                end else if (i_sts.pad_left) begin
                    o_cmd.pad = 1'b1;
                end else if (i_sts.frame_done) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_sts.last_step) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_sts.pipe_idle && i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

>>> sv/nfid_dp.sv
`include "noncausal_fir_iq_dot_assert.svh"

module nfid_dp #(
    parameter int TAP_COUNT = 33,
    parameter int HALF_SPAN = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nfid_pkg::t_cmd     i_cmd,
    input  nfid_pkg::t_item_in i_item,
    output nfid_pkg::t_sts     o_sts,
    nfid_out_if.source         o_out
);
    import nfid_pkg::*;

    localparam int AW    = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam int CW    = $clog2(TAP_COUNT + 1);
    localparam int FW    = $clog2(HALF_SPAN + 1);
    localparam int TWO_H = 2 * HALF_SPAN;
    localparam int IMAX  = (TWO_H > TAP_COUNT) ? TWO_H : TAP_COUNT;
    localparam int IW    = $clog2(IMAX + 1) + 1;
    localparam int WW    = 2 * SMP_W;

    // Sample and tap stores, I in the upper half of each word
    logic [WW-1:0]         r_dly_mem  [TAP_COUNT];
    logic [WW-1:0]         r_coef_mem [TAP_COUNT];
    logic [TAP_COUNT-1:0]  r_coef_vld;

    // Sequencing state
    logic [AW-1:0]  r_wp;
    logic [CW-1:0]  r_count;
    logic [FW-1:0]  r_fill;
    logic [FW-1:0]  r_pad;
    logic           r_frame;
    logic           r_emit;
    logic           r_last;
    logic [AW-1:0]  r_idx;
    logic [AW-1:0]  r_addr;
    logic           r_s1;
    logic           r_s2;

    // MAC pipeline
    logic [WW-1:0]             r_dly_rd;
    logic [WW-1:0]             r_coef_rd;
    logic                      r_ok1;
    logic signed [PROD_W-1:0]  r_pi;
    logic signed [PROD_W-1:0]  r_pq;
    logic signed [ACC_W-1:0]   r_acc;

    // Output register
    logic                      r_out_vld;
    logic signed [ACC_W-1:0]   r_out_filt;
    logic                      r_out_last;

    logic [AW-1:0]            n_wp;
    logic [AW-1:0]            n_addr;
    logic [CW-1:0]            n_count;
    logic [IW-1:0]            idx_x;
    logic [IW-1:0]            k_x;
    logic                     tap_ok;
    logic [AW-1:0]            coef_addr;
    logic                     tap_wr_ok;
    logic                     pad_emit;
    logic signed [SMP_W-1:0]  dly_i;
    logic signed [SMP_W-1:0]  dly_q;
    logic signed [SMP_W-1:0]  cf_i;
    logic signed [SMP_W-1:0]  cf_q;
    logic signed [PROD_W-1:0] prod_i;
    logic signed [PROD_W-1:0] prod_q;

    // Circular pointers and tap bookkeeping
    always_comb begin
        n_wp      = (r_wp == AW'(TAP_COUNT - 1)) ? '0 : r_wp + 1'b1;
        n_addr    = (r_addr == '0) ? AW'(TAP_COUNT - 1) : r_addr - 1'b1;
        n_count   = (r_count == CW'(TAP_COUNT)) ? r_count : r_count + 1'b1;
        // r_idx is the age of the sample, tap index is 2*HALF_SPAN minus age
        idx_x     = IW'(r_idx);
        k_x       = IW'(TWO_H) - idx_x;
        tap_ok    = (idx_x <= IW'(TWO_H)) && (k_x < IW'(TAP_COUNT))
                    && (idx_x < IW'(r_count));
        coef_addr = tap_ok ? k_x[AW-1:0] : '0;
        tap_wr_ok = i_item.tap_index < TAPI_W'(TAP_COUNT);
        pad_emit  = ({1'b0, r_pad} + {1'b0, r_fill}) >= (FW + 1)'(HALF_SPAN);
        dly_i     = signed'(r_dly_rd[WW-1:SMP_W]);
        dly_q     = signed'(r_dly_rd[SMP_W-1:0]);
        cf_i      = signed'(r_coef_rd[WW-1:SMP_W]);
        cf_q      = signed'(r_coef_rd[SMP_W-1:0]);
        // signed 16x16 products, kept apart so the sign survives
        prod_i    = dly_i * cf_i;
        prod_q    = dly_q * cf_q;
    end

    // Status to controller
    always_comb begin
        o_sts.emit_due   = r_emit;
        o_sts.pad_left   = r_frame && (r_pad != FW'(HALF_SPAN));
        o_sts.frame_done = r_frame && (r_pad == FW'(HALF_SPAN));
        o_sts.last_step  = (r_idx == AW'(TAP_COUNT - 1));
        o_sts.pipe_idle  = !r_s1 && !r_s2;
        o_sts.out_free   = !r_out_vld || o_out.ready;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_count    <= '0;
            r_fill     <= '0;
            r_pad      <= '0;
            r_frame    <= 1'b0;
            r_emit     <= 1'b0;
            r_last     <= 1'b0;
            r_idx      <= '0;
            r_addr     <= '0;
            r_s1       <= 1'b0;
            r_s2       <= 1'b0;
            r_out_vld  <= 1'b0;
            r_coef_vld <= '0;
        end else begin
            r_s1 <= i_cmd.step;
            r_s2 <= r_s1;
            if (i_cmd.tap_wr && tap_wr_ok) begin
                r_coef_vld[i_item.tap_index[AW-1:0]] <= 1'b1;
            end
            // new sample: owes the output of the sample HALF_SPAN pushes older once the window is full
            if (i_cmd.push) begin
                r_wp    <= n_wp;
                r_count <= n_count;
                r_last  <= 1'b0;
                r_frame <= i_item.frame_end;
                r_pad   <= '0;
                if (r_fill == FW'(HALF_SPAN)) begin
                    r_emit <= 1'b1;
                end else begin
                    r_fill <= r_fill + 1'b1;
                    r_emit <= 1'b0;
                end
            end
            // zero padding after the last sample of a frame
            if (i_cmd.pad) begin
                r_wp    <= n_wp;
                r_count <= n_count;
                r_emit  <= pad_emit;
                r_last  <= (r_pad == FW'(HALF_SPAN - 1));
                r_pad   <= r_pad + 1'b1;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_fill  <= '0;
                r_pad   <= '0;
                r_frame <= 1'b0;
            end
            if (i_cmd.dot_start) begin
                r_idx  <= '0;
                r_addr <= r_wp;
            end
            if (i_cmd.step) begin
                r_idx  <= r_idx + 1'b1;
                r_addr <= n_addr;
            end
            if (i_cmd.emit) begin
                r_emit    <= 1'b0;
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Stores: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (i_cmd.push || i_cmd.pad) begin
            r_dly_mem[n_wp] <= i_cmd.push ? {i_item.sample_i, i_item.sample_q} : '0;
        end
        if (i_cmd.tap_wr && tap_wr_ok) begin
            r_coef_mem[i_item.tap_index[AW-1:0]] <= {i_item.tap_i, i_item.tap_q};
        end
        if (i_cmd.step) begin
            r_dly_rd  <= r_dly_mem[r_addr];
            r_coef_rd <= r_coef_mem[coef_addr];
            r_ok1     <= tap_ok && r_coef_vld[coef_addr];
        end
    end

    // Complex MAC: products, then accumulate
    always_ff @(posedge i_clk) begin
        if (r_s1) begin
            r_pi <= r_ok1 ? prod_i : '0;
            r_pq <= r_ok1 ? prod_q : '0;
        end
        if (i_cmd.dot_start) begin
            r_acc <= '0;
        end else if (r_s2) begin
            r_acc <= r_acc + ACC_W'(r_pi) + ACC_W'(r_pq);
        end
        if (i_cmd.emit) begin
            r_out_filt <= r_acc;
            r_out_last <= r_last;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.filtered      = r_out_filt;
    assign o_out.last_of_frame = r_out_last;

    `NFID_ASSERT_IMP(a_emit_room, i_cmd.emit, (!r_out_vld || o_out.ready), "result overwritten")
    `NFID_ASSERT_HOLD(a_fill_range, (r_fill <= FW'(HALF_SPAN)), "fill count overrun")
    `NFID_ASSERT_IMP(a_pad_bound, i_cmd.pad, (r_frame && r_pad < FW'(HALF_SPAN)), "stray pad step")
    `NFID_ASSERT_IMP(a_last_at_end, (i_cmd.emit && r_last), (r_frame && r_pad == FW'(HALF_SPAN)), "frame end flag early")

endmodule

>>> sv/noncausal_fir_iq_dot.sv
// Centered complex FIR over I/Q samples: y[n] = sum_k tap_i[k]*x_i[n+k-HALF_SPAN]
// + tap_q[k]*x_q[n+k-HALF_SPAN], exact in 40 bits at Q.30. A sample item that
// releases an output starts a dot product on the single shared I/Q multiply-
// accumulate, which reads one tap pair and one sample pair from the stores per
// cycle. A sample marked frame_end adds HALF_SPAN zero-pad steps, each of which
// releases an output once pushed samples and pad steps together reach HALF_SPAN,
// and then clears the delay line; the last of these outputs carries last_of_frame.
// Input is stalled until all results of an item are produced; a finished result
// waits in the output register while the next dot product is being computed.
module noncausal_fir_iq_dot #(
    parameter int TAP_COUNT = 33,
    parameter int HALF_SPAN = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nfid_in_if.sink     i_in,
    nfid_out_if.source  o_out
);
    import nfid_pkg::*;

    t_cmd      w_cmd;
    t_sts      w_sts;
    t_item_in  w_item;
    logic      w_ready;

    // Gather the input payload
    always_comb begin
        w_item.func      = i_in.func;
        w_item.tap_index = i_in.tap_index;
        w_item.tap_i     = i_in.tap_i;
        w_item.tap_q     = i_in.tap_q;
        w_item.sample_i  = i_in.sample_i;
        w_item.sample_q  = i_in.sample_q;
        w_item.frame_end = i_in.frame_end;
    end

    assign i_in.ready = w_ready;

    nfid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_func  (i_in.func),
        .i_sts      (w_sts),
        .o_in_ready (w_ready),
        .o_cmd      (w_cmd)
    );

    nfid_dp #(
        .TAP_COUNT (TAP_COUNT),
        .HALF_SPAN (HALF_SPAN)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_item  (w_item),
        .o_sts   (w_sts),
        .o_out   (o_out)
    );

endmodule

>>> verif/tb_noncausal_fir_iq_dot.sv
module tb_noncausal_fir_iq_dot;
    timeunit 1ns;
    timeprecision 1ps;

    import nfid_pkg::*;

    localparam int TAPS      = 33;
    localparam int HALF      = 16;
    localparam int MAX_IDLE  = 10;
    localparam int CYCLE_CAP = 1_000_000;

    // One expected filter output
    typedef struct packed {
        logic signed [ACC_W-1:0] filtered;
        logic                    last_of_frame;
    } t_result;

    // Centered I/Q dot product predictor plus the queue of outputs it owes
    class fir_iq_checker;
        logic signed [SMP_W-1:0] coef_i [TAPS];
        logic signed [SMP_W-1:0] coef_q [TAPS];
        logic signed [SMP_W-1:0] hist_i [TAPS];
        logic signed [SMP_W-1:0] hist_q [TAPS];
        int unsigned             fill;
        t_result                 owed [$];
        int                      errors;

        function new();
            foreach (coef_i[k]) begin
                coef_i[k] = '0;
                coef_q[k] = '0;
                hist_i[k] = '0;
                hist_q[k] = '0;
            end
            fill   = 0;
            errors = 0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) begin
                $display("ERROR @%0t: %s", $time, msg);
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // newest sample goes to entry 0
        function void advance(logic signed [SMP_W-1:0] si, logic signed [SMP_W-1:0] sq);
            for (int j = TAPS - 1; j > 0; j--) begin
                hist_i[j] = hist_i[j-1];
                hist_q[j] = hist_q[j-1];
            end
            hist_i[0] = si;
            hist_q[0] = sq;
        endfunction

        // tap k meets the sample 2*HALF-k pushes old
        function logic signed [ACC_W-1:0] centered_dot();
            longint acc;
            int     idx;
            acc = 0;
            for (int k = 0; k < TAPS; k++) begin
                idx = 2 * HALF - k;
                if (idx >= 0 && idx < TAPS) begin
                    acc += longint'(coef_i[k]) * longint'(hist_i[idx]);
                    acc += longint'(coef_q[k]) * longint'(hist_q[idx]);
                end
            end
            return acc[ACC_W-1:0];
        endfunction

        function void absorb_item(t_item_in it);
            int made;
            made = 0;
            if (it.func == FUNC_TAP) begin
                if (it.tap_index < TAPS) begin
                    coef_i[it.tap_index] = it.tap_i;
                    coef_q[it.tap_index] = it.tap_q;
                end
                return;
            end
            advance(it.sample_i, it.sample_q);
            if (fill >= HALF) begin
                owed.push_back('{centered_dot(), 1'b0});
                made++;
            end else begin
                fill++;
            end
            // frame end: zero pad, flush owed outputs, clear history
            if (it.frame_end) begin
                for (int unsigned j = 0; j < HALF; j++) begin
                    advance('0, '0);
                    if (j + fill >= HALF) begin
                        owed.push_back('{centered_dot(), 1'b0});
                        made++;
                    end
                end
                if (made > 0) begin
                    owed[owed.size()-1].last_of_frame = 1'b1;
                end
                foreach (hist_i[k]) begin
                    hist_i[k] = '0;
                    hist_q[k] = '0;
                end
                fill = 0;
            end
        endfunction

        function void match_output(logic signed [ACC_W-1:0] f, logic lf);
            t_result want;
            if (owed.size() == 0) begin
                flag($sformatf("unexpected output filtered=%0d last=%0b", f, lf));
                return;
            end
            want = owed.pop_front();
            if (f !== want.filtered) begin
                flag($sformatf("filtered exp %0d got %0d", want.filtered, f));
            end
            if (lf !== want.last_of_frame) begin
                flag($sformatf("last_of_frame exp %0b got %0b", want.last_of_frame, lf));
            end
        endfunction

        function void finish_check();
            if (owed.size() != 0) begin
                flag($sformatf("%0d outputs never arrived", owed.size()));
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycle_count = 0;

    fir_iq_checker chk = new();

    nfid_in_if  in_ch ();
    nfid_out_if out_ch ();

    noncausal_fir_iq_dot #(
        .TAP_COUNT (TAPS),
        .HALF_SPAN (HALF)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #10 i_clk = ~i_clk;

    // Run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int idle_len(bit calm);
        return calm ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    // Extremes show up often, otherwise full range
    function automatic logic signed [SMP_W-1:0] rand_s16();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            default: return 16'($urandom());
        endcase
    endfunction

    // Unused fields carry noise
    function automatic t_item_in mk_tap(logic [TAPI_W-1:0] idx,
                                        logic signed [SMP_W-1:0] ti,
                                        logic signed [SMP_W-1:0] tq);
        t_item_in it;
        it.func      = FUNC_TAP;
        it.tap_index = idx;
        it.tap_i     = ti;
        it.tap_q     = tq;
        it.sample_i  = 16'($urandom());
        it.sample_q  = 16'($urandom());
        it.frame_end = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic t_item_in mk_sample(logic signed [SMP_W-1:0] si,
                                           logic signed [SMP_W-1:0] sq,
                                           logic fe);
        t_item_in it;
        it.func      = FUNC_SAMPLE;
        it.tap_index = 7'($urandom());
        it.tap_i     = 16'($urandom());
        it.tap_q     = 16'($urandom());
        it.sample_i  = si;
        it.sample_q  = sq;
        it.frame_end = fe;
        return it;
    endfunction

    // Mostly valid indexes, sometimes out of range
    function automatic t_item_in rand_tap();
        logic [TAPI_W-1:0] idx;
        if ($urandom_range(0, 5) == 0) begin
            idx = 7'($urandom_range(0, 127));
        end else begin
            idx = 7'($urandom_range(0, TAPS - 1));
        end
        return mk_tap(idx, rand_s16(), rand_s16());
    endfunction

    // Drive one item at the falling edge, hold until accepted
    task automatic send_item(t_item_in it, int gap, bit drain);
        if (drain && gap == 0) begin
            gap = 1;
        end
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            if (drain) begin
                while (chk.pending() != 0) @(negedge i_clk);
            end
            repeat (gap) @(negedge i_clk);
        end
        in_ch.func      <= it.func;
        in_ch.tap_index <= it.tap_index;
        in_ch.tap_i     <= it.tap_i;
        in_ch.tap_q     <= it.tap_q;
        in_ch.sample_i  <= it.sample_i;
        in_ch.sample_q  <= it.sample_q;
        in_ch.frame_end <= it.frame_end;
        in_ch.valid     <= 1'b1;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        chk.absorb_item(it);
    endtask

    // Output side: random stalls, with calm stretches
    initial begin
        int stall;
        bit calm;
        out_ch.ready = 1'b0;
        calm = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 15) == 0) begin
                calm = !calm;
            end
            stall = idle_len(calm);
            @(negedge i_clk);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            chk.match_output(out_ch.filtered, out_ch.last_of_frame);
        end
    end

    // Stimulus
    initial begin
        t_item_in dir_q [$];
        int       n_rand;
        int       flen;
        bit       fast;
        bit       paused;
        bit       drain;

        in_ch.valid     = 1'b0;
        in_ch.func      = FUNC_TAP;
        in_ch.tap_index = '0;
        in_ch.tap_i     = '0;
        in_ch.tap_q     = '0;
        in_ch.sample_i  = '0;
        in_ch.sample_q  = '0;
        in_ch.frame_end = 1'b0;
        i_rst_n         = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: edge taps, ignored indexes, one-sample frame, long frame
        dir_q.push_back(mk_tap(7'd0, 16'sh7fff, 16'sh8000));
        dir_q.push_back(mk_tap(7'(TAPS - 1), 16'sh8000, 16'sh7fff));
        dir_q.push_back(mk_tap(7'(HALF), 16'sh8000, 16'sh8000));
        dir_q.push_back(mk_tap(7'(TAPS), 16'sh3039, 16'shffff));
        dir_q.push_back(mk_tap(7'h7f, 16'shffff, 16'shffff));
        dir_q.push_back(mk_sample(16'sh8000, 16'sh8000, 1'b1));
        for (int k = 0; k < HALF + 2; k++) begin
            if (k % 2 == 0) begin
                dir_q.push_back(mk_sample(16'sh8000, 16'sh7fff, k == HALF + 1));
            end else begin
                dir_q.push_back(mk_sample(16'sh7fff, 16'sh8000, k == HALF + 1));
            end
        end
        foreach (dir_q[k]) begin
            send_item(dir_q[k], idle_len(k < 8), 1'b0);
        end

        // Random frames of assorted lengths with tap rewrites mixed in
        n_rand = 0;
        fast   = 1'b0;
        paused = 1'b0;
        while (n_rand < 280) begin
            case ($urandom_range(0, 3))
                0: flen = $urandom_range(1, HALF);
                1: flen = HALF + 1;
                2: flen = HALF;
                default: flen = $urandom_range(HALF + 2, 3 * HALF);
            endcase
            if ($urandom_range(0, 3) == 0) begin
                fast = !fast;
            end
            for (int k = 0; k < flen; k++) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_item(rand_tap(), idle_len(fast), 1'b0);
                    n_rand++;
                end
                drain = ($urandom_range(0, 39) == 0);
                if (!paused && n_rand >= 140) begin
                    drain  = 1'b1;
                    paused = 1'b1;
                end
                send_item(mk_sample(rand_s16(), rand_s16(), k == flen - 1),
                          idle_len(fast), drain);
                n_rand++;
            end
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b0;

        // Drain, then allow stray outputs to show up
        while (chk.pending() != 0) @(posedge i_clk);
        repeat (4 * (TAPS + 6)) @(posedge i_clk);
        chk.finish_check();
        if (chk.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+sv
sv/nfid_pkg.sv
sv/nfid_if.sv
sv/nfid_ctrl.sv
sv/nfid_dp.sv
sv/noncausal_fir_iq_dot.sv
verif/tb_noncausal_fir_iq_dot.sv
